/* hw/rtl/csp_pkg.sv */
// closed set parent table: shared widths, codes and memory transaction types
package csp_pkg;

  localparam int ID_W     = 10;
  localparam int ID_SPACE = 1 << ID_W;
  localparam int CNT_W    = 11;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_PATH   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_BROKEN = 2'd2,
    ST_LONG   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EVAL  = 2'd2
  } state_e;

  typedef struct packed {
    logic            present;
    logic [ID_W-1:0] parent;
  } entry_t;

  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    entry_t          wr_data;
  } mem_req_t;

endpackage

/* hw/rtl/csp_mem.sv */
// closed set parent table: node entry memory, one write and one registered read port
module csp_mem #(
  parameter int NODES = 1024
) (
  input  logic              clk_i,
  input  csp_pkg::mem_req_t mem_req_i,
  output csp_pkg::entry_t   rdata_o
);

  localparam int DEPTH = (NODES < csp_pkg::ID_SPACE) ? NODES : csp_pkg::ID_SPACE;
  localparam int AW    = $clog2(DEPTH);

  csp_pkg::entry_t mem_q [DEPTH];
  csp_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr[AW-1:0]] <= mem_req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd_en) begin
      rdata_q <= mem_q[mem_req_i.rd_addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/csp_ctrl.sv */
// closed set parent table: request sequencer, clearing sweep, entry count and result register
module csp_ctrl #(
  parameter int NODES    = 1024,
  parameter int MAX_PATH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [csp_pkg::REQ_W-1:0]   req_type_i,
  input  logic [csp_pkg::ID_W-1:0]    node_id_i,
  input  logic [csp_pkg::ID_W-1:0]    parent_id_i,
  input  logic [csp_pkg::ID_W-1:0]    start_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [csp_pkg::STAT_W-1:0]  status_o,
  output logic [csp_pkg::ID_W-1:0]    parent_out_o,
  output logic [csp_pkg::ID_W-1:0]    path_node_o,
  output logic [csp_pkg::CNT_W-1:0]   entry_count_o,
  output logic                        is_empty_o,
  output logic                        last_o,
  output csp_pkg::mem_req_t           mem_req_o,
  input  csp_pkg::entry_t             mem_rdata_i
);

  localparam int DEPTH  = (NODES < csp_pkg::ID_SPACE) ? NODES : csp_pkg::ID_SPACE;
  localparam int AW     = $clog2(DEPTH);
  localparam int STEP_W = $clog2(MAX_PATH + 1);

  csp_pkg::state_e                state_q, state_d;
  logic [csp_pkg::REQ_W-1:0]      req_q, req_d;
  logic [csp_pkg::ID_W-1:0]       node_q, node_d;
  logic [csp_pkg::ID_W-1:0]       par_q, par_d;
  logic [csp_pkg::ID_W-1:0]       start_q, start_d;
  logic [AW-1:0]                  sweep_q, sweep_d;
  logic                           clr_reply_q, clr_reply_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic [csp_pkg::CNT_W-1:0]      count_q, count_d;

  logic                           out_valid_q, out_valid_d;
  logic [csp_pkg::STAT_W-1:0]     status_q, status_d;
  logic [csp_pkg::ID_W-1:0]       parent_out_q, parent_out_d;
  logic [csp_pkg::ID_W-1:0]       path_node_q, path_node_d;
  logic [csp_pkg::CNT_W-1:0]      out_count_q;
  logic                           last_q, last_d;
  logic                           out_load;

  logic                           out_free;
  logic                           node_in_range;
  logic                           held;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign node_in_range = 32'(node_q) < NODES;
  assign held          = node_in_range && mem_rdata_i.present;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    node_d       = node_q;
    par_d        = par_q;
    start_d      = start_q;
    sweep_d      = sweep_q;
    clr_reply_d  = clr_reply_q;
    step_d       = step_q;
    count_d      = count_q;
    out_load     = 1'b0;
    status_d     = csp_pkg::ST_OK;
    parent_out_d = '0;
    path_node_d  = '0;
    last_d       = 1'b1;
    mem_req_o    = '0;
    in_stall_o   = 1'b1;

    unique case (state_q)
      csp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d   = req_type_i;
          node_d  = node_id_i;
          par_d   = parent_id_i;
          start_d = start_id_i;
          step_d  = '0;
          if (req_type_i == csp_pkg::REQ_CLEAR) begin
            state_d     = csp_pkg::S_CLEAR;
            sweep_d     = '0;
            clr_reply_d = 1'b1;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = node_id_i;
            state_d           = csp_pkg::S_EVAL;
          end
        end
      end

      csp_pkg::S_CLEAR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = csp_pkg::ID_W'(sweep_q);
        mem_req_o.wr_data = '0;
        sweep_d           = sweep_q + AW'(1);
        if (sweep_q == AW'(DEPTH - 1)) begin
          count_d = '0;
          state_d = clr_reply_q ? csp_pkg::S_EVAL : csp_pkg::S_IDLE;
        end
      end

      csp_pkg::S_EVAL: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (req_q)
            csp_pkg::REQ_CLEAR: begin
              status_d = csp_pkg::ST_OK;
            end
            csp_pkg::REQ_INSERT: begin
              if (!node_in_range || mem_rdata_i.present) begin
                status_d = csp_pkg::ST_MISS;
              end else begin
                mem_req_o.wr_en           = 1'b1;
                mem_req_o.wr_addr         = node_q;
                mem_req_o.wr_data.present = 1'b1;
                mem_req_o.wr_data.parent  = par_q;
                count_d                   = count_q + csp_pkg::CNT_W'(1);
              end
            end
            csp_pkg::REQ_REMOVE: begin
              if (!held) begin
                status_d = csp_pkg::ST_MISS;
              end else begin
                mem_req_o.wr_en           = 1'b1;
                mem_req_o.wr_addr         = node_q;
                mem_req_o.wr_data.present = 1'b0;
                mem_req_o.wr_data.parent  = mem_rdata_i.parent;
                count_d                   = count_q - csp_pkg::CNT_W'(1);
              end
            end
            csp_pkg::REQ_SEARCH: begin
              if (!held) begin
                status_d = csp_pkg::ST_MISS;
              end else begin
                parent_out_d = mem_rdata_i.parent;
              end
            end
            csp_pkg::REQ_PATH: begin
              path_node_d = node_q;
              priority if (node_q == start_q) begin
                status_d = csp_pkg::ST_OK;
              end else if (!held) begin
                status_d = csp_pkg::ST_BROKEN;
              end else if (step_q == STEP_W'(MAX_PATH - 1)) begin
                status_d = csp_pkg::ST_LONG;
              end else begin
                // follow the parent link, one node a cycle while the output is not stalled
                last_d            = 1'b0;
                node_d            = mem_rdata_i.parent;
                step_d            = step_q + STEP_W'(1);
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = mem_rdata_i.parent;
              end
            end
            default: begin
              status_d = csp_pkg::ST_MISS;
            end
          endcase
          if (last_d) begin
            state_d = csp_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_d = csp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csp_pkg::S_CLEAR;
      sweep_q     <= '0;
      clr_reply_q <= 1'b0;
      step_q      <= '0;
      count_q     <= '0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_reply_q <= (state_q == csp_pkg::S_CLEAR) ? clr_reply_d : (state_d == csp_pkg::S_CLEAR);
      step_q      <= step_d;
      count_q     <= count_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    par_q   <= par_d;
    start_q <= start_d;
    if (out_load) begin
      status_q     <= status_d;
      parent_out_q <= parent_out_d;
      path_node_q  <= path_node_d;
      out_count_q  <= count_d;
      last_q       <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign parent_out_o  = parent_out_q;
  assign path_node_o   = path_node_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = (out_count_q == '0);
  assign last_o        = last_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= csp_pkg::CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_write_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (state_q == csp_pkg::S_CLEAR || state_q == csp_pkg::S_EVAL))
    else $error("table written outside sweep or evaluation");

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.wr_en && mem_req_o.rd_en))
    else $error("read and write of the table in one cycle");

  a_path_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csp_pkg::S_EVAL) |-> (step_q < STEP_W'(MAX_PATH)))
    else $error("path walk beyond the cap");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && req_q == csp_pkg::REQ_CLEAR) |=> (count_q == '0 && out_valid_q))
    else $error("clear reply with table not empty");

endmodule

/* hw/rtl/closed_set_parent_table_unit.sv */
// closed set parent table: top level joining the sequencer and the node entry memory
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | req_type_i node_id_i parent_id_i start_id_i
//  out     | output    | out_valid_o / out_stall_i | status_o parent_out_o path_node_o
//          |           |                           | entry_count_o is_empty_o last_o
//
//  insert, remove, search and unknown requests: memory read, then evaluate and write
//  build path: read on acceptance, then one node per cycle while not stalled, at most MAX_PATH
//  clear: accept, a sweep of all min(NODES, 1024) memory entries, then the reply
//  after reset the same sweep runs with no reply; no transaction is taken until it ends
//  one request at a time; a stalled result holds the evaluation stage, a finished result
//  may wait in the output register while the next request is taken
module closed_set_parent_table_unit #(
  parameter int NODES    = 1024,
  parameter int MAX_PATH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [csp_pkg::REQ_W-1:0]  req_type_i,
  input  logic [csp_pkg::ID_W-1:0]   node_id_i,
  input  logic [csp_pkg::ID_W-1:0]   parent_id_i,
  input  logic [csp_pkg::ID_W-1:0]   start_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [csp_pkg::STAT_W-1:0] status_o,
  output logic [csp_pkg::ID_W-1:0]   parent_out_o,
  output logic [csp_pkg::ID_W-1:0]   path_node_o,
  output logic [csp_pkg::CNT_W-1:0]  entry_count_o,
  output logic                       is_empty_o,
  output logic                       last_o
);

  csp_pkg::mem_req_t mem_req;
  csp_pkg::entry_t   mem_rdata;

  csp_ctrl #(
    .NODES    (NODES),
    .MAX_PATH (MAX_PATH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .node_id_i     (node_id_i),
    .parent_id_i   (parent_id_i),
    .start_id_i    (start_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .parent_out_o  (parent_out_o),
    .path_node_o   (path_node_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .last_o        (last_o),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  csp_mem #(
    .NODES (NODES)
  ) u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

endmodule

/* dv/closed_set_parent_table_unit_tb.sv */
// testbench for the closed set parent table: random table and path transactions, self-checking
module closed_set_parent_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES        = 1024;
  localparam int MAX_PATH     = 64;
  localparam int ITEM_TARGET  = 410;
  localparam int LIMIT_CYCLES = 10000000;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [csp_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [csp_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [csp_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

  typedef struct packed {
    csp_pkg::status_e          status;
    logic [csp_pkg::ID_W-1:0]  parent_out;
    logic [csp_pkg::ID_W-1:0]  path_node;
    logic [csp_pkg::CNT_W-1:0] entry_count;
    logic                      is_empty;
    logic                      last;
  } table_reply_t;

  class parent_table_board;
    bit                       present [NODES];
    logic [csp_pkg::ID_W-1:0] parent_of [NODES];
    int unsigned              held;
    table_reply_t             expected_q [$];
    int                       errors;
    int                       replies_seen;

    function void push_reply(csp_pkg::status_e st, logic [csp_pkg::ID_W-1:0] par,
                             logic [csp_pkg::ID_W-1:0] node, bit fin);
      table_reply_t r;
      r.status      = st;
      r.parent_out  = par;
      r.path_node   = node;
      r.entry_count = held[csp_pkg::CNT_W-1:0];
      r.is_empty    = (held == 0);
      r.last        = fin;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_request(logic [csp_pkg::REQ_W-1:0] req, logic [csp_pkg::ID_W-1:0] node,
                               logic [csp_pkg::ID_W-1:0] par,
                               logic [csp_pkg::ID_W-1:0] start);
      csp_pkg::status_e         st;
      logic [csp_pkg::ID_W-1:0] par_out;
      logic [csp_pkg::ID_W-1:0] cur;
      int                       k;
      bit                       fin;
      st      = csp_pkg::ST_OK;
      par_out = '0;
      case (req)
        csp_pkg::REQ_CLEAR: begin
          foreach (present[i]) present[i] = 1'b0;
          held = 0;
        end
        csp_pkg::REQ_INSERT: begin
          if (present[node]) begin
            st = csp_pkg::ST_MISS;
          end else begin
            present[node]   = 1'b1;
            parent_of[node] = par;
            held++;
          end
        end
        csp_pkg::REQ_REMOVE: begin
          if (!present[node]) begin
            st = csp_pkg::ST_MISS;
          end else begin
            present[node] = 1'b0;
            held--;
          end
        end
        csp_pkg::REQ_SEARCH: begin
          if (!present[node]) st = csp_pkg::ST_MISS;
          else par_out = parent_of[node];
        end
        csp_pkg::REQ_PATH: begin
          cur = node;
          k   = 0;
          fin = 1'b0;
          while (!fin) begin
            if (cur == start) begin
              push_reply(csp_pkg::ST_OK, '0, cur, 1'b1);
              fin = 1'b1;
            end else if (!present[cur]) begin
              push_reply(csp_pkg::ST_BROKEN, '0, cur, 1'b1);
              fin = 1'b1;
            end else if (k + 1 >= MAX_PATH) begin
              push_reply(csp_pkg::ST_LONG, '0, cur, 1'b1);
              fin = 1'b1;
            end else begin
              push_reply(csp_pkg::ST_OK, '0, cur, 1'b0);
              k++;
              cur = parent_of[cur];
            end
          end
          return;
        end
        default: st = csp_pkg::ST_MISS;
      endcase
      push_reply(st, par_out, '0, 1'b1);
    endfunction

    function void check_reply(table_reply_t got);
      table_reply_t want;
      replies_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected reply: no transaction pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.parent_out !== want.parent_out) begin
        $error("parent_out: expected %0d, actual %0d", want.parent_out, got.parent_out);
        errors++;
      end
      if (got.path_node !== want.path_node) begin
        $error("path_node: expected %0d, actual %0d", want.path_node, got.path_node);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function void report_leftovers();
      if (expected_q.size() != 0) begin
        $error("%0d expected replies never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [csp_pkg::REQ_W-1:0]  req_type_i  = '0;
  logic [csp_pkg::ID_W-1:0]   node_id_i   = '0;
  logic [csp_pkg::ID_W-1:0]   parent_id_i = '0;
  logic [csp_pkg::ID_W-1:0]   start_id_i  = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [csp_pkg::STAT_W-1:0] status_o;
  logic [csp_pkg::ID_W-1:0]   parent_out_o;
  logic [csp_pkg::ID_W-1:0]   path_node_o;
  logic [csp_pkg::CNT_W-1:0]  entry_count_o;
  logic                       is_empty_o;
  logic                       last_o;

  parent_table_board        board = new();
  bit                       claimed [NODES];
  logic [csp_pkg::ID_W-1:0] recent [$];
  int                       items_sent;
  int                       burst_left;
  int                       cycle_count;
  bit                       hold_done;

  closed_set_parent_table_unit #(
    .NODES   (NODES),
    .MAX_PATH(MAX_PATH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .node_id_i    (node_id_i),
    .parent_id_i  (parent_id_i),
    .start_id_i   (start_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .parent_out_o (parent_out_o),
    .path_node_o  (path_node_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    table_reply_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.status      = csp_pkg::status_e'(status_o);
      got.parent_out  = parent_out_o;
      got.path_node   = path_node_o;
      got.entry_count = entry_count_o;
      got.is_empty    = is_empty_o;
      got.last        = last_o;
      board.check_reply(got);
    end
  end

  // receiver: random stalls, quiet stretches and one long hold
  initial begin
    int r;
    int run;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && board.replies_seen >= 150) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(50, 200)) @(posedge clk_i);
        end else begin
          run = (r < 90) ? $urandom_range(0, 3) : $urandom_range(16, 40);
          if (run > 0) begin
            out_stall_i <= 1'b1;
            repeat (run) @(posedge clk_i);
          end
          out_stall_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_req(logic [csp_pkg::REQ_W-1:0] req, logic [csp_pkg::ID_W-1:0] node,
                          logic [csp_pkg::ID_W-1:0] par, logic [csp_pkg::ID_W-1:0] start);
    int r;
    int gap;
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    node_id_i   <= node;
    parent_id_i <= par;
    start_id_i  <= start;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
    board.note_request(req, node, par, start);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) burst_left = 40;
      else if (r >= 65 && r < 93) gap = $urandom_range(1, 3);
      else if (r >= 93) gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [csp_pkg::ID_W-1:0] any_node();
    return csp_pkg::ID_W'($urandom_range(0, NODES - 1));
  endfunction

  function automatic logic [csp_pkg::ID_W-1:0] pick_free();
    logic [csp_pkg::ID_W-1:0] n;
    int                       tries;
    n     = any_node();
    tries = 0;
    while ((board.present[n] || claimed[n]) && tries < 200) begin
      n = any_node();
      tries++;
    end
    return n;
  endfunction

  function automatic logic [csp_pkg::ID_W-1:0] pick_node();
    if (recent.size() != 0 && $urandom_range(0, 1) == 0)
      return recent[$urandom_range(0, recent.size() - 1)];
    return any_node();
  endfunction

  task automatic send_noise();
    logic [csp_pkg::REQ_W-1:0] req;
    if ($urandom_range(0, 99) < 2) begin
      req = csp_pkg::REQ_CLEAR;
    end else begin
      req = csp_pkg::REQ_W'($urandom_range(32'(csp_pkg::REQ_INSERT), 32'(REQ_RSVD7)));
    end
    send_req(req, pick_node(), any_node(), pick_node());
  endtask

  // chain of fresh nodes linked parent to parent, then walked, searched and cut
  task automatic run_chain();
    logic [csp_pkg::ID_W-1:0] chain [$];
    logic [csp_pkg::ID_W-1:0] n;
    logic [csp_pkg::ID_W-1:0] tail_par;
    int                       len;
    int                       i;
    int                       r;
    if (board.held > 700) send_req(csp_pkg::REQ_CLEAR, pick_node(), pick_node(), pick_node());
    len = ($urandom_range(0, 9) < 2) ? $urandom_range(60, 66) : $urandom_range(1, 12);
    for (i = 0; i < len; i++) begin
      n = pick_free();
      claimed[n] = 1'b1;
      chain.insert(chain.size(), n);
    end
    tail_par = ($urandom_range(0, 3) == 0) ? chain[$urandom_range(0, len - 1)] : pick_free();
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_req(csp_pkg::REQ_INSERT, chain[i], (i < len - 1) ? chain[i + 1] : tail_par,
               any_node());
      recent.insert(recent.size(), chain[i]);
      if (recent.size() > 64) void'(recent.pop_front());
    end
    foreach (claimed[j]) claimed[j] = 1'b0;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        send_req(csp_pkg::REQ_PATH, chain[$urandom_range(0, (len - 1) / 4)], pick_node(),
                 chain[len - 1]);
      end else if (r < 7) begin
        send_req(csp_pkg::REQ_REMOVE, chain[$urandom_range(0, len - 1)], pick_node(),
                 pick_node());
        send_req(csp_pkg::REQ_PATH, chain[0], pick_node(), chain[len - 1]);
      end else if (r < 8) begin
        send_req(csp_pkg::REQ_SEARCH, chain[$urandom_range(0, len - 1)], pick_node(),
                 pick_node());
      end else begin
        send_req(csp_pkg::REQ_PATH, chain[$urandom_range(0, len - 1)], pick_node(),
                 any_node());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(csp_pkg::REQ_PATH,   10'd5,    10'd0,    10'd5);
    send_req(csp_pkg::REQ_SEARCH, 10'd0,    10'd1023, 10'd0);
    send_req(csp_pkg::REQ_REMOVE, 10'd1023, 10'd0,    10'd1023);
    send_req(csp_pkg::REQ_INSERT, 10'd0,    10'd1023, 10'd0);
    send_req(csp_pkg::REQ_INSERT, 10'd0,    10'd5,    10'd0);
    send_req(csp_pkg::REQ_INSERT, 10'd1023, 10'd0,    10'd1023);
    send_req(csp_pkg::REQ_SEARCH, 10'd0,    10'd0,    10'd0);
    send_req(csp_pkg::REQ_SEARCH, 10'd1023, 10'd1023, 10'd1023);
    send_req(csp_pkg::REQ_PATH,   10'd0,    10'd0,    10'd1023);
    send_req(csp_pkg::REQ_PATH,   10'd0,    10'd0,    10'd512);
    send_req(csp_pkg::REQ_INSERT, 10'd682,  10'd341,  10'd341);
    send_req(csp_pkg::REQ_PATH,   10'd682,  10'd682,  10'd0);
    send_req(REQ_RSVD5,           10'd0,    10'd0,    10'd0);
    send_req(REQ_RSVD6,           10'd341,  10'd682,  10'd682);
    send_req(REQ_RSVD7,           10'd1023, 10'd1023, 10'd1023);
    send_req(csp_pkg::REQ_REMOVE, 10'd0,    10'd0,    10'd0);
    send_req(csp_pkg::REQ_PATH,   10'd1023, 10'd0,    10'd700);
    send_req(csp_pkg::REQ_CLEAR,  10'd0,    10'd0,    10'd0);
    send_req(csp_pkg::REQ_SEARCH, 10'd1023, 10'd0,    10'd0);
    send_req(csp_pkg::REQ_INSERT, 10'd1023, 10'd1023, 10'd1023);
    send_req(csp_pkg::REQ_PATH,   10'd1023, 10'd0,    10'd1);
    send_req(csp_pkg::REQ_PATH,   10'd5,    10'd0,    10'd6);
    send_req(csp_pkg::REQ_CLEAR,  10'd1023, 10'd1023, 10'd1023);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else run_chain();
    end
    in_valid_i <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_PATH + 16) @(posedge clk_i);
    board.report_leftovers();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/csp_pkg.sv
hw/rtl/csp_mem.sv
hw/rtl/csp_ctrl.sv
hw/rtl/closed_set_parent_table_unit.sv
dv/closed_set_parent_table_unit_tb.sv
